FILE: sv/depth_first_search_timestamps_defines.svh
// Shared assertion macros for the search block checkers.
`ifndef DEPTH_FIRST_SEARCH_TIMESTAMPS_DEFINES_SVH
`define DEPTH_FIRST_SEARCH_TIMESTAMPS_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DFST_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DFST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/dfst_pkg.sv
package dfst_pkg;

    typedef struct packed {
        logic [1:0] op;
        logic [5:0] vertex_a;
        logic [5:0] vertex_b;
    } t_in_word;

    typedef struct packed {
        logic [5:0] vertex;
        logic [6:0] discovery_number;
        logic [7:0] finish_number;
        logic       status;
        logic       last;
    } t_out_word;

    localparam logic [1:0] OP_ADD_EDGE = 2'd0;
    localparam logic [1:0] OP_SEARCH   = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;
    localparam logic [1:0] OP_NONE     = 2'd3;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    localparam logic       REG_VCOUNT    = 1'b0;
    localparam logic [6:0] VCOUNT_RESET  = 7'd64;

    typedef logic [4:0] t_step;

    localparam t_step ST_IDLE     = 5'd0;
    localparam t_step ST_OP_NONE  = 5'd1;
    localparam t_step ST_OP_CLEAR = 5'd2;
    localparam t_step ST_OP_SRCH  = 5'd3;
    localparam t_step ST_EDGE_RD  = 5'd4;
    localparam t_step ST_EDGE_WA  = 5'd5;
    localparam t_step ST_EDGE_WB  = 5'd6;
    localparam t_step ST_CLEAR    = 5'd7;
    localparam t_step ST_SEARCH   = 5'd8;
    localparam t_step ST_INIT     = 5'd9;
    localparam t_step ST_SETTLE   = 5'd10;
    localparam t_step ST_CHECK    = 5'd11;
    localparam t_step ST_PUSHED   = 5'd12;
    localparam t_step ST_POP      = 5'd13;
    localparam t_step ST_POP_RD   = 5'd14;
    localparam t_step ST_EMIT     = 5'd15;
    localparam t_step ST_EMITTED  = 5'd16;
    localparam t_step ST_ERROR    = 5'd17;

    typedef enum logic [3:0] {
        C_NONE       = 4'd0,
        C_ALWAYS     = 4'd1,
        C_OP_NONE    = 4'd2,
        C_OP_CLEAR   = 4'd3,
        C_OP_SEARCH  = 4'd4,
        C_EDGE_BAD   = 4'd5,
        C_START_BAD  = 4'd6,
        C_CAND_ZERO  = 4'd7,
        C_DEPTH_ZERO = 4'd8
    } t_cond;

    typedef enum logic [1:0] {
        RS_CUR = 2'd0,
        RS_A   = 2'd1,
        RS_B   = 2'd2
    } t_rsel;

    typedef struct packed {
        logic  take;
        t_rsel adj_rsel;
        logic  we_a;
        logic  we_b;
        logic  clr;
        logic  init;
        logic  push;
        logic  pop;
        logic  emit_ok;
        logic  emit_err;
    } t_ctl;

    typedef struct packed {
        logic  gate;
        t_cond cond;
        t_step target;
        t_ctl  ops;
    } t_uword;

    typedef struct packed {
        logic op_none;
        logic op_clear;
        logic op_search;
        logic edge_bad;
        logic start_bad;
        logic cand_zero;
        logic depth_zero;
        logic out_free;
    } t_stat;

    function automatic t_uword dfst_urom(input t_step step);
        t_uword w;
        w = '0;
        w.ops.adj_rsel = RS_CUR;
        case (step)
            ST_IDLE: begin
                w.ops.take = 1'b1;
            end
            ST_OP_NONE: begin
                w.cond   = C_OP_NONE;
                w.target = ST_IDLE;
            end
            ST_OP_CLEAR: begin
                w.cond   = C_OP_CLEAR;
                w.target = ST_CLEAR;
            end
            ST_OP_SRCH: begin
                w.cond   = C_OP_SEARCH;
                w.target = ST_SEARCH;
            end
            ST_EDGE_RD: begin
                w.cond         = C_EDGE_BAD;
                w.target       = ST_IDLE;
                w.ops.adj_rsel = RS_A;
            end
            ST_EDGE_WA: begin
                w.ops.adj_rsel = RS_B;
                w.ops.we_a     = 1'b1;
            end
            ST_EDGE_WB: begin
                w.cond     = C_ALWAYS;
                w.target   = ST_IDLE;
                w.ops.we_b = 1'b1;
            end
            ST_CLEAR: begin
                w.cond    = C_ALWAYS;
                w.target  = ST_IDLE;
                w.ops.clr = 1'b1;
            end
            ST_SEARCH: begin
                w.cond   = C_START_BAD;
                w.target = ST_ERROR;
            end
            ST_INIT: begin
                w.ops.init = 1'b1;
            end
            ST_SETTLE: begin
                w.cond = C_NONE;
            end
            ST_CHECK: begin
                w.gate     = 1'b1;
                w.cond     = C_CAND_ZERO;
                w.target   = ST_POP;
                w.ops.push = 1'b1;
            end
            ST_PUSHED: begin
                w.cond   = C_ALWAYS;
                w.target = ST_CHECK;
            end
            ST_POP: begin
                w.ops.pop = 1'b1;
            end
            ST_POP_RD: begin
                w.cond = C_NONE;
            end
            ST_EMIT: begin
                w.cond        = C_DEPTH_ZERO;
                w.target      = ST_IDLE;
                w.ops.emit_ok = 1'b1;
            end
            ST_EMITTED: begin
                w.cond   = C_ALWAYS;
                w.target = ST_CHECK;
            end
            ST_ERROR: begin
                w.cond         = C_ALWAYS;
                w.target       = ST_IDLE;
                w.ops.emit_err = 1'b1;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: sv/dfst_ram.sv
module dfst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/dfst_seq.sv
module dfst_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  dfst_pkg::t_stat i_stat,
    output dfst_pkg::t_ctl  o_ctl,
    output logic          o_in_stall
);

    dfst_pkg::t_step  r_upc;
    dfst_pkg::t_step  n_upc;
    dfst_pkg::t_uword w;
    logic             cond_true;
    logic             hold;
    logic             fire;

    assign w = dfst_pkg::dfst_urom(r_upc);

    always_comb begin
        case (w.cond)
            dfst_pkg::C_NONE:       cond_true = 1'b0;
            dfst_pkg::C_ALWAYS:     cond_true = 1'b1;
            dfst_pkg::C_OP_NONE:    cond_true = i_stat.op_none;
            dfst_pkg::C_OP_CLEAR:   cond_true = i_stat.op_clear;
            dfst_pkg::C_OP_SEARCH:  cond_true = i_stat.op_search;
            dfst_pkg::C_EDGE_BAD:   cond_true = i_stat.edge_bad;
            dfst_pkg::C_START_BAD:  cond_true = i_stat.start_bad;
            dfst_pkg::C_CAND_ZERO:  cond_true = i_stat.cand_zero;
            dfst_pkg::C_DEPTH_ZERO: cond_true = i_stat.depth_zero;
            default:                cond_true = 1'b0;
        endcase
    end

    assign hold = (w.ops.take && !i_in_valid)
               || ((w.ops.emit_ok || w.ops.emit_err) && !i_stat.out_free);
    assign fire = !hold && !(w.gate && cond_true);

    always_comb begin
        o_ctl          = '0;
        o_ctl.adj_rsel = w.ops.adj_rsel;
        if (fire) begin
            o_ctl = w.ops;
        end
    end

    always_comb begin
        if (hold) begin
            n_upc = r_upc;
        end else if (cond_true) begin
            n_upc = w.target;
        end else begin
            n_upc = r_upc + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= dfst_pkg::ST_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_in_stall = !w.ops.take;

endmodule

FILE: sv/dfst_dp.sv
module dfst_dp #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dfst_pkg::t_in_word  i_in_data,
    input  logic                i_out_stall,
    input  logic [6:0]          i_vcount,
    input  dfst_pkg::t_ctl      i_ctl,
    output dfst_pkg::t_stat     o_stat,
    output logic                o_out_valid,
    output dfst_pkg::t_out_word o_out_data
);

    localparam int         VW   = $clog2(MAX_VERTICES);
    localparam int         DW   = $clog2(MAX_VERTICES + 1);
    localparam logic [6:0] MAXV = 7'(MAX_VERTICES);

    logic [1:0]              r_op;
    logic [5:0]              r_a;
    logic [5:0]              r_b;
    logic [MAX_VERTICES-1:0] r_visited;
    logic [MAX_VERTICES-1:0] r_row_vld;
    logic                    r_rd_vld;
    logic [DW-1:0]           r_depth;
    logic [7:0]              r_time;
    logic [VW-1:0]           r_cur;
    logic                    r_out_valid;
    dfst_pkg::t_out_word     r_out;

    logic [6:0]              live_n;
    logic [MAX_VERTICES-1:0] live_mask;
    logic                    a_ok;
    logic                    b_ok;
    logic [VW-1:0]           a_idx;
    logic [VW-1:0]           b_idx;
    logic [MAX_VERTICES-1:0] a_bit;
    logic [MAX_VERTICES-1:0] b_bit;
    logic [VW-1:0]           adj_raddr;
    logic [VW-1:0]           adj_waddr;
    logic [MAX_VERTICES-1:0] adj_wdata;
    logic [MAX_VERTICES-1:0] adj_rdata;
    logic                    adj_we;
    logic [MAX_VERTICES-1:0] rd_row;
    logic [MAX_VERTICES-1:0] cand;
    logic [VW-1:0]           pick;
    logic                    stk_we;
    logic [VW-1:0]           stk_waddr;
    logic [VW-1:0]           stk_wdata;
    logic [DW-1:0]           depth_m1;
    logic [VW-1:0]           stk_rdata;
    logic                    disc_we;
    logic [VW-1:0]           disc_waddr;
    logic [6:0]              disc_wdata;
    logic [6:0]              disc_rdata;
    logic                    out_free;

    assign live_n = (i_vcount > MAXV) ? MAXV : i_vcount;
    assign a_ok   = {1'b0, r_a} < live_n;
    assign b_ok   = {1'b0, r_b} < live_n;
    assign a_idx  = r_a[VW-1:0];
    assign b_idx  = r_b[VW-1:0];
    assign a_bit  = MAX_VERTICES'(1) << a_idx;
    assign b_bit  = MAX_VERTICES'(1) << b_idx;

    always_comb begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            live_mask[i] = 7'(i) < live_n;
        end
    end

    always_comb begin
        case (i_ctl.adj_rsel)
            dfst_pkg::RS_A: adj_raddr = a_idx;
            dfst_pkg::RS_B: adj_raddr = b_idx;
            default:        adj_raddr = r_cur;
        endcase
    end

    assign rd_row    = r_rd_vld ? adj_rdata : '0;
    assign adj_we    = i_ctl.we_a || i_ctl.we_b;
    assign adj_waddr = i_ctl.we_a ? a_idx : b_idx;
    assign adj_wdata = rd_row | (i_ctl.we_a ? b_bit : a_bit);

    assign cand = rd_row & ~r_visited & live_mask;

    always_comb begin
        pick = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
            if (cand[i]) begin
                pick = VW'(i);
            end
        end
    end

    assign stk_we     = i_ctl.init || i_ctl.push;
    assign stk_waddr  = i_ctl.init ? '0 : r_depth[VW-1:0];
    assign stk_wdata  = i_ctl.init ? a_idx : pick;
    assign depth_m1   = r_depth - DW'(1);
    assign disc_we    = i_ctl.init || i_ctl.push;
    assign disc_waddr = i_ctl.init ? a_idx : pick;
    assign disc_wdata = i_ctl.init ? 7'd1 : r_time[6:0];

    dfst_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    dfst_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (depth_m1[VW-1:0]),
        .o_rdata (stk_rdata)
    );

    dfst_ram #(.WIDTH(7), .DEPTH(MAX_VERTICES)) u_disc (
        .i_clk   (i_clk),
        .i_we    (disc_we),
        .i_waddr (disc_waddr),
        .i_wdata (disc_wdata),
        .i_raddr (r_cur),
        .o_rdata (disc_rdata)
    );

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visited   <= '0;
            r_row_vld   <= '0;
            r_depth     <= '0;
            r_time      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.clr) begin
                r_row_vld <= '0;
            end else if (adj_we) begin
                r_row_vld[adj_waddr] <= 1'b1;
            end
            if (i_ctl.init) begin
                r_visited <= a_bit;
                r_depth   <= DW'(1);
                r_time    <= 8'd2;
            end else if (i_ctl.push) begin
                r_visited <= r_visited | (MAX_VERTICES'(1) << pick);
                r_depth   <= r_depth + DW'(1);
                r_time    <= r_time + 8'd1;
            end else if (i_ctl.pop) begin
                r_depth <= depth_m1;
            end else if (i_ctl.emit_ok) begin
                r_time <= r_time + 8'd1;
            end
            if (i_ctl.emit_ok || i_ctl.emit_err) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_row_vld[adj_raddr];
        if (i_ctl.take) begin
            r_op <= i_in_data.op;
            r_a  <= i_in_data.vertex_a;
            r_b  <= i_in_data.vertex_b;
        end
        if (i_ctl.init) begin
            r_cur <= a_idx;
        end else if (i_ctl.push) begin
            r_cur <= pick;
        end else if (i_ctl.emit_ok) begin
            r_cur <= stk_rdata;
        end
        if (i_ctl.emit_ok) begin
            r_out.vertex           <= 6'(r_cur);
            r_out.discovery_number <= disc_rdata;
            r_out.finish_number    <= r_time;
            r_out.status           <= dfst_pkg::STATUS_OK;
            r_out.last             <= (r_depth == '0);
        end else if (i_ctl.emit_err) begin
            r_out.vertex           <= r_a;
            r_out.discovery_number <= '0;
            r_out.finish_number    <= '0;
            r_out.status           <= dfst_pkg::STATUS_RANGE;
            r_out.last             <= 1'b1;
        end
    end

    assign o_stat.op_none    = (r_op == dfst_pkg::OP_NONE);
    assign o_stat.op_clear   = (r_op == dfst_pkg::OP_CLEAR);
    assign o_stat.op_search  = (r_op == dfst_pkg::OP_SEARCH);
    assign o_stat.edge_bad   = !(a_ok && b_ok);
    assign o_stat.start_bad  = !a_ok;
    assign o_stat.cand_zero  = (cand == '0);
    assign o_stat.depth_zero = (r_depth == '0);
    assign o_stat.out_free   = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: sv/depth_first_search_timestamps.sv
// Edge add, graph clear and search each run as a microprogram from idle; a search
// with a bad start vertex ends in a range-error word. A search is paced by the
// microprogram's check/push/pop steps around the single adjacency RAM read port.
// One word at a time; results leave through a one-word output register.
// Reset (synchronous, active low) empties the graph at once through per-row
// valid flops, restores vertex_count to 64 and returns the sequencer to idle.
module depth_first_search_timestamps #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                i_in_valid,
    input  dfst_pkg::t_in_word  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output dfst_pkg::t_out_word o_out_data,
    input  logic                i_out_stall
);

    logic [6:0]      r_vcount;
    logic            reg_hit;
    dfst_pkg::t_ctl  ctl;
    dfst_pkg::t_stat stat;

    assign reg_hit = (paddr[2] == dfst_pkg::REG_VCOUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= dfst_pkg::VCOUNT_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_vcount <= pwdata[6:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = reg_hit ? {25'd0, r_vcount} : 32'd0;

    dfst_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_ctl      (ctl),
        .o_in_stall (o_in_stall)
    );

    dfst_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_vcount    (r_vcount),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: sv/dfst_chk.sv
`include "depth_first_search_timestamps_defines.svh"

module dfst_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input dfst_pkg::t_out_word o_out_data,
    input logic                i_out_stall
);

    logic in_take;
    logic out_ok;
    logic out_err;

    assign in_take = i_in_valid && !o_in_stall;
    assign out_ok  = o_out_valid && (o_out_data.status == dfst_pkg::STATUS_OK);
    assign out_err = o_out_valid && (o_out_data.status == dfst_pkg::STATUS_RANGE);

    `DFST_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result word changed")
    `DFST_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, in_take, o_in_stall, "word taken while previous one in progress")
    `DFST_ASSERT_NOW(a_err_shape, i_clk, i_rst_n, out_err, o_out_data.last && (o_out_data.discovery_number == 7'd0) && (o_out_data.finish_number == 8'd0), "malformed error word")
    `DFST_ASSERT_NOW(a_time_order, i_clk, i_rst_n, out_ok, (o_out_data.discovery_number != 7'd0) && (o_out_data.finish_number > {1'b0, o_out_data.discovery_number}), "finish not after discovery")

endmodule

bind depth_first_search_timestamps dfst_chk u_dfst_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);
